FILE: rtl/core/ocec_pkg.sv
// ----------------------------------------------------------------------------
// ocec_pkg
// Shared codes, constants and the CRC column function of the on-die codec.
// ----------------------------------------------------------------------------
package ocec_pkg;

    // Polynomials without their top term.
    localparam logic [15:0] POLY8_LOW  = 16'h00CF;
    localparam logic [15:0] POLY16_LOW = 16'h5935;

    localparam int CHECK_BITS_MAX = 16;
    localparam int CHECK_BITS_MIN = 8;
    localparam int POSITION_BITS  = 8;

    typedef enum logic
    {
        CMD_ENCODE = 1'b0,
        CMD_CHECK  = 1'b1
    } command_t;

    typedef enum logic [1:0]
    {
        STATUS_OK            = 2'd0,
        STATUS_CORRECTED     = 2'd1,
        STATUS_UNCORRECTABLE = 2'd2
    } status_t;

    // Contribution of a single set data bit to the final register: the bit
    // loads the polynomial, and the register then shifts on with zero data.
    function automatic logic [15:0] crc_column(input logic [15:0] poly_low,
                                               input int width,
                                               input int shifts);
        logic [15:0] r;
        logic [15:0] mask;
        logic        fb;
        int          k;
        mask = (width == CHECK_BITS_MAX) ? 16'hFFFF : 16'h00FF;
        r    = poly_low & mask;
        for (k = 0; k < shifts; k++)
        begin
            fb = r[width - 1];
            r  = (r << 1) & mask;
            if (fb)
            begin
                r = r ^ poly_low;
            end
        end
        return r & mask;
    endfunction

endpackage

FILE: rtl/core/ocec_if.sv
// ----------------------------------------------------------------------------
// ocec_if
// Request, result and configuration channels of the on-die codec.
// ----------------------------------------------------------------------------
interface ocec_req_if import ocec_pkg::*; ();
    logic         valid;
    logic         ready;
    command_t     command;
    logic [63:0]  data_low;
    logic [63:0]  data_high;
    logic [15:0]  check_in;

    modport source (output valid, command, data_low, data_high, check_in,
                    input ready);
    modport sink   (input valid, command, data_low, data_high, check_in,
                    output ready);
endinterface

interface ocec_rsp_if import ocec_pkg::*; ();
    logic         valid;
    logic         ready;
    logic [15:0]  check_out;
    status_t      status;
    logic [POSITION_BITS-1:0] flip_position;

    modport source (output valid, check_out, status, flip_position,
                    input ready);
    modport sink   (input valid, check_out, status, flip_position,
                    output ready);
endinterface

interface ocec_cfg_if import ocec_pkg::*; ();
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/core/ondie_crc_ecc_codec_core.sv
// ----------------------------------------------------------------------------
// ondie_crc_ecc_codec_core
// CRC-8 / CRC-16 encoder and single-flip checker for one data word.
// ----------------------------------------------------------------------------
// Each request carries a data word of DATA_BITS bits and a set of check bits.
// An encode request returns the CRC of the data (CRC-8 with polynomial
// 0x1CF, or CRC-16 with polynomial 0x15935, as the mode register selects);
// data bit 0 is the first bit into the register. A check request treats the
// data and the check bits in use as an error pattern: exactly one set bit is
// reported as a corrected single flip with its position (data bit i as i,
// check bit j as DATA_BITS + j); otherwise the syndrome, which is the CRC
// XOR the received check bits, tells no error from a detected uncorrectable
// one. The block takes one request in every cycle unless the sink holds a
// result back. A request is held in the input register and its result in
// the result register; the XOR tree over the data bits and the single-bit
// test sit between the two registers. The result register holds a result
// while the sink stalls, and the input register takes the next request as
// soon as the result register can move on. The mode register should only
// be written while no request is in flight.
// ----------------------------------------------------------------------------
module ondie_crc_ecc_codec_core
    import ocec_pkg::*;
#(
    parameter int DATA_BITS = 128
)
(
    input  logic        clk,
    input  logic        rst_n,
    ocec_req_if.sink    req,
    ocec_rsp_if.source  rsp,
    ocec_cfg_if.sink    cfg
);

    localparam int VEC_BITS = DATA_BITS + CHECK_BITS_MAX;
    localparam int POS_BITS = $clog2(VEC_BITS);

    // Mode register: 0 selects CRC-8, 1 selects CRC-16.
    logic crc_mode_reg;

    // Input stage.
    logic                 s1_valid_reg;
    command_t             command_reg;
    logic [DATA_BITS-1:0] data_reg;
    logic [15:0]          check_reg;

    // Result stage.
    logic                     rsp_valid_reg;
    logic [15:0]              check_out_reg;
    logic [15:0]              check_out_next;
    status_t                  status_reg;
    status_t                  status_next;
    logic [POSITION_BITS-1:0] flip_reg;
    logic [POSITION_BITS-1:0] flip_next;

    logic         rsp_advance;
    logic         req_accept;
    logic [127:0] full_data;

    logic [7:0]  term8  [DATA_BITS];
    logic [15:0] term16 [DATA_BITS];
    logic [7:0]  crc8;
    logic [15:0] crc16;
    logic [15:0] crc;
    logic [15:0] chk;
    logic [15:0] syn;
    logic [VEC_BITS-1:0] vec;
    logic                single_flip;
    logic [POS_BITS-1:0] pos;

    // The configuration port never stalls.
    assign cfg.ready = 1'b1;

    // The result register moves on when it is empty or being taken; the
    // input register follows it, so a request enters in every cycle unless
    // the sink holds a result back.
    assign rsp_advance = !rsp_valid_reg || rsp.ready;
    assign req.ready   = !s1_valid_reg || rsp_advance;
    assign req_accept  = req.valid && req.ready;

    assign full_data = {req.data_high, req.data_low};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_mode_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                crc_mode_reg <= cfg.data;
            end
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (rsp_advance)
            begin
                rsp_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            command_reg <= req.command;
            data_reg    <= full_data[DATA_BITS-1:0];
            check_reg   <= req.check_in;
        end
        if (rsp_advance && s1_valid_reg)
        begin
            check_out_reg <= check_out_next;
            status_reg    <= status_next;
            flip_reg      <= flip_next;
        end
    end

    // The CRC is linear in the data, so each data bit contributes a fixed
    // column worked out at elaboration, and the register value is the XOR
    // of the columns of the set bits.
    for (genvar g = 0; g < DATA_BITS; g++)
    begin : g_col
        localparam logic [15:0] COL8  =
            crc_column(POLY8_LOW, CHECK_BITS_MIN, DATA_BITS - 1 - g);
        localparam logic [15:0] COL16 =
            crc_column(POLY16_LOW, CHECK_BITS_MAX, DATA_BITS - 1 - g);
        assign term8[g]  = {8{data_reg[g]}} & COL8[7:0];
        assign term16[g] = {16{data_reg[g]}} & COL16;
    end

    always_comb
    begin
        crc8  = '0;
        crc16 = '0;
        for (int i = 0; i < DATA_BITS; i++)
        begin
            crc8  = crc8 ^ term8[i];
            crc16 = crc16 ^ term16[i];
        end
    end

    // In CRC-8 mode the upper check bits are neither used nor counted.
    assign crc = crc_mode_reg ? crc16 : {8'h00, crc8};
    assign chk = crc_mode_reg ? check_reg : {8'h00, check_reg[7:0]};
    assign syn = crc ^ chk;
    assign vec = {chk, data_reg};

    // Exactly one set bit: nonzero, and the pattern equals the single bit
    // that the OR of the set indices points at. With two or more bits set
    // the pattern holds more than that one bit, so the compare fails.
    assign single_flip = (vec != '0) && (vec == (VEC_BITS'(1) << pos));

    // For a one-hot pattern the OR of the indices of the set bits is the
    // index of the single bit.
    always_comb
    begin
        pos = '0;
        for (int i = 0; i < VEC_BITS; i++)
        begin
            if (vec[i])
            begin
                pos = pos | POS_BITS'(i);
            end
        end
    end

    always_comb
    begin
        check_out_next = crc;
        status_next    = STATUS_OK;
        flip_next      = '0;
        unique case (command_reg)
            CMD_ENCODE:
            begin
                check_out_next = crc;
            end
            CMD_CHECK:
            begin
                check_out_next = syn;
                if (single_flip)
                begin
                    status_next = STATUS_CORRECTED;
                    flip_next   = POSITION_BITS'(pos);
                end
                else if (syn != '0)
                begin
                    status_next = STATUS_UNCORRECTABLE;
                end
            end
            default:
            begin
                check_out_next = crc;
            end
        endcase
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.check_out     = check_out_reg;
    assign rsp.status        = status_reg;
    assign rsp.flip_position = flip_reg;

endmodule
